### rtl/hpl_pkg.sv
`default_nettype none
package hpl_pkg;

  // Field widths
  localparam int TEMP_WIDTH_DEF = 10;
  localparam int COLD_W         = 10;
  localparam int POLL_W         = 8;
  localparam int MARGIN_W       = 6;
  localparam int LEVEL_W        = 8;
  localparam int KIND_W         = 2;

  // APB port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_COLD_LIMIT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLD_DEFAULT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_POLL_INTERVAL = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_NEAR_MARGIN   = 2'd3;

  // Register reset values
  localparam logic [COLD_W-1:0]   COLD_LIMIT_RST    = 10'd50;
  localparam logic [COLD_W-1:0]   COLD_DEFAULT_RST  = 10'd25;
  localparam logic [POLL_W-1:0]   POLL_INTERVAL_RST = 8'd200;
  localparam logic [MARGIN_W-1:0] NEAR_MARGIN_RST   = 6'd5;

  // Color kinds
  localparam logic [KIND_W-1:0] KIND_OFF   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GREEN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEAT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WHITE = 2'd3;

  // Level map ranges
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [LEVEL_W-1:0] HOT_BASE  = 8'd125;
  localparam logic [LEVEL_W-1:0] SPAN_FULL = LEVEL_MAX;
  localparam logic [LEVEL_W-1:0] SPAN_BED  = HOT_BASE;
  localparam logic [LEVEL_W-1:0] SPAN_HOT  = LEVEL_MAX - HOT_BASE;

  typedef struct packed {
    logic [COLD_W-1:0]   cold_limit;
    logic [COLD_W-1:0]   cold_default;
    logic [POLL_W-1:0]   poll_interval;
    logic [MARGIN_W-1:0] near_margin;
  } hpl_cfg_t;

  typedef struct packed {
    logic load_in;
    logic tick_step;
    logic decide;
    logic mul;
    logic div_step;
    logic finish;
    logic push_out;
  } hpl_cmd_t;

  typedef struct packed {
    logic tick_zero;
    logic has_result;
    logic needs_map;
    logic div_done;
    logic level_up;
    logic out_free;
  } hpl_status_t;

endpackage
`default_nettype wire

### rtl/hpl_if.sv
`default_nettype none
interface hpl_tick_if
  import hpl_pkg::*;
#(
  parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  printing;
  logic                  on_print_screen;
  logic [TEMP_WIDTH-1:0] hotend_temp;
  logic [TEMP_WIDTH-1:0] bed_temp;
  logic [TEMP_WIDTH-1:0] hotend_target;
  logic [TEMP_WIDTH-1:0] bed_target;

  modport source (output valid, printing, on_print_screen, hotend_temp, bed_temp,
                  hotend_target, bed_target, input ready);
  modport sink (input valid, printing, on_print_screen, hotend_temp, bed_temp,
                hotend_target, bed_target, output ready);
endinterface

interface hpl_light_if
  import hpl_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  color_kind;
  logic [LEVEL_W-1:0] red;
  logic [LEVEL_W-1:0] green;
  logic [LEVEL_W-1:0] blue;

  modport source (output valid, color_kind, red, green, blue, input ready);
  modport sink (input valid, color_kind, red, green, blue, output ready);
endinterface
`default_nettype wire

### rtl/hpl_regs.sv
`default_nettype none
module hpl_regs
  import hpl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      hpl_cfg_t              cfg
);

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx = paddr[REG_IDX_W+1:2];
  assign wr  = psel && penable && pwrite;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cold_limit    <= COLD_LIMIT_RST;
      cfg.cold_default  <= COLD_DEFAULT_RST;
      cfg.poll_interval <= POLL_INTERVAL_RST;
      cfg.near_margin   <= NEAR_MARGIN_RST;
    end else if (wr) begin
      unique case (idx)
        REG_COLD_LIMIT:    cfg.cold_limit    <= pwdata[COLD_W-1:0];
        REG_COLD_DEFAULT:  cfg.cold_default  <= pwdata[COLD_W-1:0];
        REG_POLL_INTERVAL: cfg.poll_interval <= pwdata[POLL_W-1:0];
        REG_NEAR_MARGIN:   cfg.near_margin   <= pwdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_COLD_LIMIT:    prdata = APB_DATA_W'(cfg.cold_limit);
      REG_COLD_DEFAULT:  prdata = APB_DATA_W'(cfg.cold_default);
      REG_POLL_INTERVAL: prdata = APB_DATA_W'(cfg.poll_interval);
      REG_NEAR_MARGIN:   prdata = APB_DATA_W'(cfg.near_margin);
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/hpl_ctrl.sv
`default_nettype none
module hpl_ctrl
  import hpl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire hpl_status_t status,
  output      hpl_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // Sequence one tick through prescaler, decision, map and output
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.tick_step = 1'b1;
        state_next    = status.tick_zero ? ST_DECIDE : ST_IDLE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (status.has_result) begin
          state_next = ST_OUT;
        end else if (status.needs_map) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = status.level_up ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.push_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### rtl/hpl_dp.sv
`default_nettype none
module hpl_dp
  import hpl_pkg::*;
#(
  parameter int TW = TEMP_WIDTH_DEF
)(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hpl_cfg_t           cfg,
  input  wire hpl_cmd_t           cmd,
  output      hpl_status_t        status,
  input  wire logic               printing,
  input  wire logic               on_print_screen,
  input  wire logic [TW-1:0]      hotend_temp,
  input  wire logic [TW-1:0]      bed_temp,
  input  wire logic [TW-1:0]      hotend_target,
  input  wire logic [TW-1:0]      bed_target,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [KIND_W-1:0]  out_kind,
  output      logic [LEVEL_W-1:0] out_red,
  output      logic [LEVEL_W-1:0] out_green,
  output      logic [LEVEL_W-1:0] out_blue
);

  localparam int CMPW = (TW > COLD_W) ? TW : COLD_W;
  localparam int PW   = TW + 1 + LEVEL_W;
  localparam int SCW  = $clog2(PW + 1);

  // Latched tick
  logic          printing_q;
  logic          screen_q;
  logic [TW-1:0] ht;
  logic [TW-1:0] bt;
  logic [TW-1:0] htg;
  logic [TW-1:0] btg;

  // Persistent state
  logic [POLL_W-1:0]  countdown;
  logic [TW-1:0]      room;
  logic [LEVEL_W-1:0] last_level;
  logic               heat_reached;
  logic               print_finished;

  // Pending result
  logic [KIND_W-1:0]  res_kind;
  logic [LEVEL_W-1:0] res_red;
  logic [LEVEL_W-1:0] res_green;
  logic [LEVEL_W-1:0] res_blue;

  // Map operands and divider
  logic [LEVEL_W-1:0] olo;
  logic [LEVEL_W-1:0] span;
  logic [TW:0]        diff_mag;
  logic               diff_neg;
  logic [TW:0]        den_mag;
  logic               den_neg;
  logic               den_zero;
  logic [TW:0]        rem;
  logic [PW-1:0]      quo;
  logic [SCW-1:0]     step_cnt;

  // Room estimate
  logic            hot_cold;
  logic            bed_cold;
  logic [TW:0]     cold_sum;
  logic [CMPW-1:0] cd_ext;

  assign hot_cold = CMPW'(ht) < CMPW'(cfg.cold_limit);
  assign bed_cold = CMPW'(bt) < CMPW'(cfg.cold_limit);
  assign cold_sum = (hot_cold ? {1'b0, ht} : '0) + (bed_cold ? {1'b0, bt} : '0);
  assign cd_ext   = CMPW'(cfg.cold_default);

  // Decision logic
  logic               both_on;
  logic               hot_near;
  logic               bed_near;
  logic               has_result;
  logic               needs_map;
  logic [KIND_W-1:0]  d_kind;
  logic [LEVEL_W-1:0] d_red;
  logic [LEVEL_W-1:0] d_green;
  logic [LEVEL_W-1:0] d_blue;
  logic [TW:0]        map_x;
  logic [TW:0]        map_hi;
  logic [LEVEL_W-1:0] map_olo;
  logic [LEVEL_W-1:0] map_span;
  logic [TW+1:0]      diff_w;
  logic [TW+1:0]      den_w;

  assign both_on  = (htg != '0) && (btg != '0);
  assign hot_near = ({1'b0, ht} + (TW+1)'(cfg.near_margin)) >= {1'b0, htg};
  assign bed_near = ({1'b0, bt} + (TW+1)'(cfg.near_margin)) >= {1'b0, btg};

  always_comb begin
    has_result = 1'b0;
    needs_map  = 1'b0;
    d_kind     = KIND_OFF;
    d_red      = '0;
    d_green    = '0;
    d_blue     = '0;
    map_x      = {1'b0, ht};
    map_hi     = {1'b0, htg};
    map_olo    = HOT_BASE;
    map_span   = SPAN_HOT;
    if (!printing_q) begin
      if (last_level != '0) begin
        if (!screen_q) begin
          has_result = 1'b1;
        end else if (!print_finished) begin
          has_result = 1'b1;
          d_kind     = KIND_GREEN;
          d_green    = LEVEL_MAX;
        end
      end
    end else if (!heat_reached && ((htg != '0) || (btg != '0))) begin
      if (both_on && hot_near && bed_near) begin
        has_result = 1'b1;
        d_kind     = KIND_WHITE;
        d_red      = LEVEL_MAX;
        d_green    = LEVEL_MAX;
        d_blue     = LEVEL_MAX;
      end else begin
        needs_map = 1'b1;
        if (both_on && bed_near) begin
          map_x    = {1'b0, ht} + {1'b0, bt};
          map_hi   = {1'b0, htg} + {1'b0, btg};
          map_olo  = '0;
          map_span = SPAN_FULL;
        end else if (htg == '0) begin
          map_x    = {1'b0, bt};
          map_hi   = {1'b0, btg};
          map_olo  = '0;
          map_span = SPAN_BED;
        end
      end
    end
  end

  assign diff_w = {1'b0, map_x} - {2'b00, room};
  assign den_w  = {1'b0, map_hi} - {2'b00, room};

  // Divider step
  logic [TW+1:0] rem_sh;
  logic          q_bit;

  assign rem_sh = {rem, quo[PW-1]};
  assign q_bit  = rem_sh >= {1'b0, den_mag};

  // Level from quotient, clamped to the output range
  logic [LEVEL_W-1:0] q_sat;
  logic [LEVEL_W-1:0] level;

  assign q_sat = (quo > PW'(span)) ? span : quo[LEVEL_W-1:0];

  always_comb begin
    if (den_zero) begin
      level = diff_neg ? olo : olo + span;
    end else if ((diff_mag != '0) && (diff_neg != den_neg)) begin
      level = olo;
    end else begin
      level = olo + q_sat;
    end
  end

  assign status.tick_zero  = (countdown == '0);
  assign status.has_result = has_result;
  assign status.needs_map  = needs_map;
  assign status.div_done   = (step_cnt == '0);
  assign status.level_up   = level > last_level;
  assign status.out_free   = !out_valid || out_ready;

  // Capture the tick
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      printing_q <= printing;
      screen_q   <= on_print_screen;
      ht         <= hotend_temp;
      bt         <= bed_temp;
      htg        <= hotend_target;
      btg        <= bed_target;
    end
  end

  // Prescaler, room estimate and light state
  always_ff @(posedge clk) begin
    if (rst) begin
      countdown      <= '0;
      room           <= '0;
      last_level     <= '0;
      heat_reached   <= 1'b0;
      print_finished <= 1'b0;
    end else begin
      if (cmd.tick_step) begin
        if (countdown != '0) begin
          countdown <= countdown - 1'b1;
        end else begin
          countdown <= cfg.poll_interval;
          if (room == '0) begin
            if (cold_sum == '0) begin
              room <= cd_ext[TW-1:0];
            end else if (hot_cold && bed_cold) begin
              room <= cold_sum[TW:1];
            end else begin
              room <= cold_sum[TW-1:0];
            end
          end
        end
      end
      if (cmd.decide) begin
        if (!printing_q && (last_level != '0)) begin
          heat_reached <= 1'b0;
          if (!screen_q) begin
            last_level     <= '0;
            print_finished <= 1'b0;
          end else begin
            print_finished <= 1'b1;
          end
        end
        if (printing_q && has_result) begin
          heat_reached <= 1'b1;
        end
      end
      if (cmd.finish && status.level_up) begin
        last_level <= level;
      end
    end
  end

  // Pending result and map operands
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_kind  <= d_kind;
      res_red   <= d_red;
      res_green <= d_green;
      res_blue  <= d_blue;
      olo       <= map_olo;
      span      <= map_span;
      diff_neg  <= diff_w[TW+1];
      diff_mag  <= diff_w[TW+1] ? (TW+1)'(-diff_w) : diff_w[TW:0];
      den_neg   <= den_w[TW+1];
      den_mag   <= den_w[TW+1] ? (TW+1)'(-den_w) : den_w[TW:0];
      den_zero  <= (den_w == '0);
    end
    if (cmd.finish) begin
      res_kind  <= KIND_HEAT;
      res_red   <= level;
      res_green <= '0;
      res_blue  <= LEVEL_MAX - level;
    end
  end

  // Multiply then divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.mul) begin
      step_cnt <= SCW'(PW);
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo <= PW'(diff_mag * span);
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[PW-2:0], q_bit};
      rem <= q_bit ? (TW+1)'(rem_sh - {1'b0, den_mag}) : rem_sh[TW:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_out) begin
      out_kind  <= res_kind;
      out_red   <= res_red;
      out_green <= res_green;
      out_blue  <= res_blue;
    end
  end

endmodule
`default_nettype wire

### rtl/heating_progress_led_indicator.sv
// Sequence: a tick skipped by the prescaler goes back to idle after evaluation; a direct result
//   (off, green, white) goes from the decision to the output register and the tick is done.
// A mapped level goes through multiply, the restoring divider of the linear map and a finish
//   step before output; the divider retires one quotient bit per cycle.
// One tick at a time: a new tick is taken only once the last is done; a stalled result holds.
// Reset (synchronous, active high) clears prescaler, room, level and flags, loads defaults.
`default_nettype none
module heating_progress_led_indicator
  import hpl_pkg::*;
#(
  parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
)(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready,
  hpl_tick_if.sink                   tick,
  hpl_light_if.source                light
);

  hpl_cfg_t    cfg;
  hpl_cmd_t    cmd;
  hpl_status_t status;

  assign pready = 1'b1;

  hpl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  hpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .in_ready (tick.ready),
    .status   (status),
    .cmd      (cmd)
  );

  hpl_dp #(
    .TW (TEMP_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .status          (status),
    .printing        (tick.printing),
    .on_print_screen (tick.on_print_screen),
    .hotend_temp     (tick.hotend_temp),
    .bed_temp        (tick.bed_temp),
    .hotend_target   (tick.hotend_target),
    .bed_target      (tick.bed_target),
    .out_valid       (light.valid),
    .out_ready       (light.ready),
    .out_kind        (light.color_kind),
    .out_red         (light.red),
    .out_green       (light.green),
    .out_blue        (light.blue)
  );

endmodule
`default_nettype wire

### rtl/hpl_checker.sv
`default_nettype none
module hpl_checker
  import hpl_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [KIND_W-1:0]  color_kind,
  input wire logic [LEVEL_W-1:0] red,
  input wire logic [LEVEL_W-1:0] green,
  input wire logic [LEVEL_W-1:0] blue
);

  logic               out_xfer;
  logic [LEVEL_W-1:0] level_seen;

  assign out_xfer = out_valid && out_ready;

  // Track the last progress level shown since the light went off
  always_ff @(posedge clk) begin
    if (rst) begin
      level_seen <= '0;
    end else if (out_xfer && (color_kind == KIND_HEAT)) begin
      level_seen <= red;
    end else if (out_xfer && (color_kind == KIND_OFF)) begin
      level_seen <= '0;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color_kind) && $stable(red)
      && $stable(green) && $stable(blue))
    else $error("stalled result changed");

  a_color_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (color_kind == KIND_OFF && red == '0 && green == '0 && blue == '0) ||
      (color_kind == KIND_GREEN && red == '0 && green == LEVEL_MAX && blue == '0) ||
      (color_kind == KIND_WHITE && red == LEVEL_MAX && green == LEVEL_MAX
        && blue == LEVEL_MAX) ||
      (color_kind == KIND_HEAT && green == '0 && (red ^ blue) == LEVEL_MAX))
    else $error("color does not match its kind");

  a_level_rises: assert property (@(posedge clk) disable iff (rst)
    out_xfer && (color_kind == KIND_HEAT) |-> red > level_seen)
    else $error("progress level did not rise");

endmodule

bind heating_progress_led_indicator hpl_checker u_hpl_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (light.valid),
  .out_ready  (light.ready),
  .color_kind (light.color_kind),
  .red        (light.red),
  .green      (light.green),
  .blue       (light.blue)
);
`default_nettype wire
